// ----- src/sjep_pkg.sv -----
// Shared types, codes and character helpers for the JSON event parser.
package sjep_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int MAX_EV    = 3;
    localparam int CHAR_W    = 8;
    localparam int POS_W     = 32;

    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_U      = 8'h75;
    localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
    localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

    typedef enum logic [2:0] {
        LK_NONE   = 3'd0,
        LK_VALUE  = 3'd1,
        LK_STRING = 3'd2,
        LK_KEY    = 3'd3,
        LK_RAW    = 3'd4
    } leaf_kind_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_BODY  = 2'd1,
        PH_ESC   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        CT_OBJ_KEY   = 3'd0,
        CT_OBJ_COLON = 3'd1,
        CT_OBJ_VALUE = 3'd2,
        CT_OBJ_SEP   = 3'd3,
        CT_ARR_FIRST = 3'd4,
        CT_ARR_NEXT  = 3'd5
    } cont_t;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_OBJ_START = 4'd1,
        EV_OBJ_END   = 4'd2,
        EV_ARR_START = 4'd3,
        EV_ARR_END   = 4'd4,
        EV_KEY_CHAR  = 4'd5,
        EV_KEY_END   = 4'd6,
        EV_VAL_CHAR  = 4'd7,
        EV_VAL_END   = 4'd8,
        EV_DONE      = 4'd9
    } event_t;

    typedef enum logic [3:0] {
        ERR_OK        = 4'd0,
        ERR_INVALID   = 4'd2,
        ERR_STR_START = 4'd3,
        ERR_COMMA_END = 4'd4,
        ERR_VALUE_END = 4'd5,
        ERR_COLON     = 4'd6,
        ERR_VALUE     = 4'd7,
        ERR_KEY_END   = 4'd8,
        ERR_SEP_END   = 4'd9,
        ERR_INTERNAL  = 4'd10,
        ERR_TOO_DEEP  = 4'd11
    } err_t;

    localparam logic [3:0] STATUS_OK   = 4'd0;
    localparam logic [3:0] STATUS_DONE = 4'd1;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        leaf_kind_t         leaf;
        phase_t             phase;
        logic               finished;
        err_t               err;
        logic [POS_W-1:0]   count;
    } parser_state_t;

    localparam parser_state_t RESET_STATE = '{
        depth:    '0,
        leaf:     LK_VALUE,
        phase:    PH_START,
        finished: 1'b0,
        err:      ERR_OK,
        count:    '0
    };

    typedef struct packed {
        event_t [MAX_EV-1:0]             ev;
        logic [MAX_EV-1:0][CHAR_W-1:0]   data;
        logic [1:0]                      num;
        logic [3:0]                      status;
        logic [POS_W-1:0]                position;
    } result_t;

    typedef struct packed {
        parser_state_t nxt;
        logic          top_we;
        cont_t         top_code;
        logic          push_we;
        cont_t         push_code;
        result_t       res;
    } step_t;

    function automatic logic is_raw(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == 8'h2B || c == 8'h2D ||
               c == 8'h2E;
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_quote(input logic [CHAR_W-1:0] c);
        return c == CH_DQUOTE || c == CH_SQUOTE;
    endfunction

    function automatic logic [CHAR_W-1:0] esc_map(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c == CH_N) begin
            r = CH_LF;
        end else if (c == CH_R) begin
            r = CH_CR;
        end else if (c == CH_T) begin
            r = CH_TAB;
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == '1) ? v : v + POS_W'(1);
    endfunction

endpackage

// ----- src/sjep_step.sv -----
// Next-state and event logic for one input character.
module sjep_step (
    input  logic                          op,
    input  logic [sjep_pkg::CHAR_W-1:0]   ch,
    input  sjep_pkg::parser_state_t       st,
    input  sjep_pkg::cont_t               top,
    output sjep_pkg::step_t               step
);
    import sjep_pkg::*;

    always_comb begin
        parser_state_t     nx;
        logic              top_we;
        cont_t             top_code;
        logic              push_we;
        cont_t             push_code;
        logic [2:0]        sv;
        event_t [2:0]      sc;
        logic [2:0][7:0]   sd;
        logic              v_ok;
        leaf_kind_t        v_leaf;
        logic              v_set_ph;
        phase_t            v_ph;
        logic              v_ev_v;
        event_t            v_ev;
        logic [7:0]        v_d;
        logic              v_push;
        cont_t             v_code;
        err_t              v_err;
        logic              deep;
        logic              in_body;
        logic              go;
        logic              to_cont;
        logic              consumed;
        logic              key;
        logic [1:0]        k;
        result_t           res;

        nx        = st;
        top_we    = 1'b0;
        top_code  = CT_OBJ_KEY;
        push_we   = 1'b0;
        push_code = CT_OBJ_KEY;
        sv        = '0;
        sc        = {EV_NONE, EV_NONE, EV_NONE};
        sd        = '0;
        consumed  = 1'b0;
        to_cont   = 1'b0;
        key       = (st.leaf == LK_KEY);
        in_body   = (st.leaf == LK_STRING || st.leaf == LK_KEY) && st.phase == PH_BODY;
        go        = st.err == ERR_OK && (st.leaf != LK_NONE || st.depth != '0);
        deep      = st.depth >= DEPTH_W'(MAX_DEPTH);

        // value start, shared by the leaf path and the container path
        v_ok     = 1'b0;
        v_leaf   = LK_NONE;
        v_set_ph = 1'b0;
        v_ph     = PH_START;
        v_ev_v   = 1'b0;
        v_ev     = EV_NONE;
        v_d      = '0;
        v_push   = 1'b0;
        v_code   = CT_OBJ_KEY;
        v_err    = ERR_OK;
        if (ch == CH_LBRACE || ch == CH_LBRACK) begin
            if (deep) begin
                v_err  = ERR_TOO_DEEP;
                v_leaf = LK_VALUE;
            end else begin
                v_ok   = 1'b1;
                v_push = 1'b1;
                v_code = (ch == CH_LBRACE) ? CT_OBJ_KEY : CT_ARR_FIRST;
                v_ev_v = 1'b1;
                v_ev   = (ch == CH_LBRACE) ? EV_OBJ_START : EV_ARR_START;
            end
        end else if (ch == CH_U || is_quote(ch)) begin
            v_ok     = 1'b1;
            v_leaf   = LK_STRING;
            v_set_ph = 1'b1;
            v_ph     = (ch == CH_U) ? PH_START : PH_BODY;
        end else if (is_raw(ch)) begin
            v_ok   = 1'b1;
            v_leaf = LK_RAW;
            v_ev_v = 1'b1;
            v_ev   = EV_VAL_CHAR;
            v_d    = ch;
        end else if (st.depth == '0) begin
            v_err = ERR_INVALID;
        end

        if (op) begin
            nx = RESET_STATE;
        end else if (ch != CH_NUL) begin
            if (is_space(ch) && !in_body) begin
                nx.count = sat_inc(st.count);
            end else begin
                if (go) begin
                    case (st.leaf)
                        LK_VALUE: begin
                            nx.leaf = v_leaf;
                            if (v_set_ph) begin
                                nx.phase = v_ph;
                            end
                            push_we   = v_push;
                            push_code = v_code;
                            if (v_push) begin
                                nx.depth = st.depth + DEPTH_W'(1);
                            end
                            sv[0]    = v_ev_v;
                            sc[0]    = v_ev;
                            sd[0]    = v_d;
                            nx.err   = v_err;
                            consumed = v_ok;
                            to_cont  = !v_ok && v_err == ERR_OK;
                        end
                        LK_STRING, LK_KEY: begin
                            case (st.phase)
                                PH_START: begin
                                    if (ch == CH_U) begin
                                        consumed = 1'b1;
                                    end else if (is_quote(ch)) begin
                                        nx.phase = PH_BODY;
                                        consumed = 1'b1;
                                    end else begin
                                        nx.err = ERR_STR_START;
                                    end
                                end
                                PH_BODY: begin
                                    consumed = 1'b1;
                                    if (is_quote(ch)) begin
                                        sv[0]   = 1'b1;
                                        sc[0]   = key ? EV_KEY_END : EV_VAL_END;
                                        nx.leaf = LK_NONE;
                                    end else if (ch == CH_BSLASH) begin
                                        nx.phase = PH_ESC;
                                    end else begin
                                        sv[0] = 1'b1;
                                        sc[0] = key ? EV_KEY_CHAR : EV_VAL_CHAR;
                                        sd[0] = ch;
                                    end
                                end
                                default: begin
                                    consumed = 1'b1;
                                    sv[0]    = 1'b1;
                                    sc[0]    = key ? EV_KEY_CHAR : EV_VAL_CHAR;
                                    sd[0]    = esc_map(ch);
                                    nx.phase = PH_BODY;
                                end
                            endcase
                        end
                        LK_RAW: begin
                            sv[0] = 1'b1;
                            if (is_raw(ch)) begin
                                sc[0]    = EV_VAL_CHAR;
                                sd[0]    = ch;
                                consumed = 1'b1;
                            end else begin
                                sc[0]   = EV_VAL_END;
                                nx.leaf = LK_NONE;
                                to_cont = st.depth != '0;
                            end
                        end
                        default: begin
                            to_cont = 1'b1;
                        end
                    endcase
                end

                if (to_cont) begin
                    case (top)
                        CT_OBJ_KEY: begin
                            if (ch == CH_RBRACE) begin
                                sv[1]    = 1'b1;
                                sc[1]    = EV_OBJ_END;
                                nx.depth = st.depth - DEPTH_W'(1);
                                consumed = 1'b1;
                            end else begin
                                top_we   = 1'b1;
                                top_code = CT_OBJ_COLON;
                                nx.leaf  = LK_KEY;
                                nx.phase = PH_START;
                                if (ch == CH_U) begin
                                    consumed = 1'b1;
                                end else if (is_quote(ch)) begin
                                    nx.phase = PH_BODY;
                                    consumed = 1'b1;
                                end else begin
                                    nx.err = ERR_KEY_END;
                                end
                            end
                        end
                        CT_OBJ_COLON: begin
                            if (ch == CH_COLON) begin
                                top_we   = 1'b1;
                                top_code = CT_OBJ_VALUE;
                                consumed = 1'b1;
                            end else begin
                                nx.err = ERR_COLON;
                            end
                        end
                        CT_OBJ_VALUE, CT_ARR_FIRST: begin
                            top_we   = 1'b1;
                            top_code = (top == CT_OBJ_VALUE) ? CT_OBJ_SEP : CT_ARR_NEXT;
                            nx.leaf  = v_leaf;
                            if (v_set_ph) begin
                                nx.phase = v_ph;
                            end
                            push_we   = v_push;
                            push_code = v_code;
                            if (v_push) begin
                                nx.depth = st.depth + DEPTH_W'(1);
                            end
                            sv[1] = v_ev_v;
                            sc[1] = v_ev;
                            sd[1] = v_d;
                            if (v_ok) begin
                                consumed = 1'b1;
                            end else if (v_err != ERR_OK) begin
                                nx.err = v_err;
                            end else if (top == CT_OBJ_VALUE) begin
                                nx.err = ERR_VALUE;
                            end else if (ch == CH_RBRACK) begin
                                sv[1]    = 1'b1;
                                sc[1]    = EV_ARR_END;
                                nx.depth = st.depth - DEPTH_W'(1);
                                consumed = 1'b1;
                            end else begin
                                nx.err = ERR_VALUE_END;
                            end
                        end
                        CT_OBJ_SEP: begin
                            if (ch == CH_RBRACE) begin
                                sv[1]    = 1'b1;
                                sc[1]    = EV_OBJ_END;
                                nx.depth = st.depth - DEPTH_W'(1);
                                consumed = 1'b1;
                            end else if (ch == CH_COMMA) begin
                                top_we   = 1'b1;
                                top_code = CT_OBJ_COLON;
                                nx.leaf  = LK_KEY;
                                nx.phase = PH_START;
                                consumed = 1'b1;
                            end else begin
                                nx.err = ERR_SEP_END;
                            end
                        end
                        default: begin
                            if (ch == CH_COMMA) begin
                                nx.leaf  = LK_VALUE;
                                consumed = 1'b1;
                            end else if (ch == CH_RBRACK) begin
                                sv[1]    = 1'b1;
                                sc[1]    = EV_ARR_END;
                                nx.depth = st.depth - DEPTH_W'(1);
                                consumed = 1'b1;
                            end else begin
                                nx.err = ERR_COMMA_END;
                            end
                        end
                    endcase
                end

                if (consumed) begin
                    nx.count = sat_inc(st.count);
                end
                if (nx.leaf == LK_NONE && nx.depth == '0 && nx.err == ERR_OK &&
                    !st.finished) begin
                    nx.finished = 1'b1;
                    sv[2]       = 1'b1;
                    sc[2]       = EV_DONE;
                end
            end
        end

        // pack events in order, leaf then container then done
        res.ev   = {EV_NONE, EV_NONE, EV_NONE};
        res.data = '0;
        k        = 2'd0;
        for (int i = 0; i < MAX_EV; i++) begin
            if (sv[i]) begin
                res.ev[k]   = sc[i];
                res.data[k] = sd[i];
                k           = k + 2'd1;
            end
        end
        res.num      = (k == 2'd0) ? 2'd1 : k;
        res.status   = (nx.err != ERR_OK) ? nx.err :
                       (nx.finished ? STATUS_DONE : STATUS_OK);
        res.position = nx.count;

        step.nxt       = nx;
        step.top_we    = top_we;
        step.top_code  = top_code;
        step.push_we   = push_we;
        step.push_code = push_code;
        step.res       = res;
    end

endmodule

// ----- src/sjep_out.sv -----
// Result buffer: holds the events of one character and drains one per transfer.
module sjep_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  sjep_pkg::result_t   res,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,   // event_res[3:0], data_char[11:4],
                                           // status[15:12], position[47:16]
    output logic                m_tlast
);
    import sjep_pkg::*;

    result_t    buf_reg;
    logic [1:0] cnt_reg;
    logic [1:0] rd_reg;
    logic       at_last;

    assign m_tvalid = cnt_reg != 2'd0;
    assign at_last  = rd_reg == cnt_reg - 2'd1;
    assign m_tlast  = at_last;
    assign free     = !m_tvalid || (m_tready && at_last);
    assign m_tdata  = {buf_reg.position, buf_reg.status, buf_reg.data[rd_reg],
                       buf_reg.ev[rd_reg]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end else if (load) begin
            cnt_reg <= res.num;
            rd_reg  <= 2'd0;
        end else if (m_tvalid && m_tready) begin
            if (at_last) begin
                cnt_reg <= 2'd0;
                rd_reg  <= 2'd0;
            end else begin
                rd_reg <= rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= res;
        end
    end

    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> rd_reg < cnt_reg)
        else $error("read slot beyond stored events");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_tvalid && rd_reg == 2'd0)
        else $error("loaded events not presented");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(rd_reg) && $stable(cnt_reg))
        else $error("result changed while stalled");

endmodule

// ----- src/streaming_json_event_parser_core.sv -----
// Streaming JSON event parser: one text byte in, one to three parse events out.
// Each accepted transfer on s_ carries one byte (s_tdata) and an operation flag
// (s_tuser: 0 parse, 1 restart). It is registered, decoded against the top of the
// container stack, and its events land in a result buffer that drains one event
// per m_ transfer; m_tlast marks the last event of that byte. A byte per clock is
// sustained with m_tready held high while each byte yields one event; a byte that
// yields more events holds the input until its last event is taken, as there is a
// single result port. Nesting is limited to MAX_DEPTH containers; deeper opens
// report too deep. Status codes are sticky until a restart.
module streaming_json_event_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // character[7:0]
    input  logic [0:0]  s_tuser,    // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // event_res[3:0], data_char[11:4],
                                    // status[15:12], position[47:16]
    output logic        m_tlast
);
    import sjep_pkg::*;

    logic                in_valid_reg;
    logic                in_op_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    parser_state_t       st_reg;
    cont_t               stack_reg [MAX_DEPTH];
    cont_t               top;
    logic [IDX_W-1:0]    top_idx;
    logic [DEPTH_W-1:0]  depth_m1;
    step_t               step;
    logic                out_free;
    logic                fire;

    assign depth_m1 = st_reg.depth - DEPTH_W'(1);
    assign top_idx  = depth_m1[IDX_W-1:0];
    assign top      = stack_reg[top_idx];
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser[0];
            in_char_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= RESET_STATE;
        end else if (fire) begin
            st_reg <= step.nxt;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && step.top_we) begin
            stack_reg[top_idx] <= step.top_code;
        end
        if (fire && step.push_we) begin
            stack_reg[st_reg.depth[IDX_W-1:0]] <= step.push_code;
        end
    end

    sjep_step u_step (
        .op   (in_op_reg),
        .ch   (in_char_reg),
        .st   (st_reg),
        .top  (top),
        .step (step)
    );

    sjep_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res      (step.res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.depth <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth beyond limit");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && step.push_we |-> st_reg.depth < DEPTH_W'(MAX_DEPTH))
        else $error("push on full stack");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && st_reg.err != ERR_OK && !in_op_reg |=> $stable(st_reg.err))
        else $error("error code changed without restart");

endmodule
